/* rtl/core/vbpu_pkg.sv */
// shared types and constants for the vertical bit pack/unpack block
package vbpu_pkg;

  localparam int MAX_ITEMS = 4096;
  localparam int ADDR_W    = 12;  // packed word address
  localparam int CNT_W     = 13;  // item count, cursor, block length
  localparam int WID_W     = 6;   // bit width, lane
  localparam int WORD_W    = 32;

  localparam logic [2:0] OP_RESTART = 3'd0;
  localparam logic [2:0] OP_PACK    = 3'd1;
  localparam logic [2:0] OP_READ    = 3'd2;
  localparam logic [2:0] OP_WRITE   = 3'd3;
  localparam logic [2:0] OP_UNPACK  = 3'd4;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_CURSOR = 2'd1;
  localparam logic [1:0] STAT_RANGE  = 2'd2;

  // configuration register indexes (byte address bit 2)
  localparam logic REG_BIT_WIDTH  = 1'b0;
  localparam logic REG_ITEM_COUNT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_LANES,
    ST_DIV_BLEN,
    ST_EXEC
  } state_t;

endpackage

/* rtl/core/vertical_bit_pack_unpack.sv */
// vertical bit pack/unpack: packed word store, cursors and shared divider
//
// usage
//   config: apb-style port, bit_width at byte address 0, item_count at 4;
//     writes only while busy is low and no result is pending
//   request: operation, value and word_index are taken at a clock edge with
//     start high and busy low; busy stays high until the request is done
//   result: data and status appear for exactly one cycle with done high;
//     the receiver cannot stall, so nothing is held back
//   pack, read, write, unpack and unused codes: the store is read at the
//     accepting edge and updated in the exec cycle, so a new request can be
//     taken in the cycle that done is high
//   restart: the one restoring divider first finds lanes = 32/w, then
//     block_length = ceil(count/lanes), one quotient bit a cycle
//   reset: cursors and block_length clear, bit_width 1, item_count 4096;
//     the packed store keeps no valid bits, a word reads as garbage until
//     it is written by pack or write
module vertical_bit_pack_unpack (
  input  logic                        clk,
  input  logic                        rst,
  // request channel
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  operation,
  input  logic [vbpu_pkg::WORD_W-1:0] value,
  input  logic [vbpu_pkg::ADDR_W-1:0] word_index,
  // result channel
  output logic                        done,
  output logic [vbpu_pkg::WORD_W-1:0] data,
  output logic [1:0]                  status,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import vbpu_pkg::*;

  // configuration registers
  logic [WID_W-1:0] bit_width;
  logic [CNT_W-1:0] item_count;

  // request registers
  logic [2:0]        op_q;
  logic [WORD_W-1:0] val_q;
  logic [ADDR_W-1:0] idx_q;

  // cursors and block geometry
  logic [CNT_W-1:0]  pack_cursor, unpack_cursor;
  logic [WID_W-1:0]  pack_lane, unpack_lane;
  logic [ADDR_W-1:0] pack_word, unpack_word;
  logic [CNT_W-1:0]  block_length;

  // shared restoring divider
  logic [WID_W-1:0] div_rem, div_den;
  logic [CNT_W-1:0] div_quo;
  logic [3:0]       div_cnt;
  logic [WID_W:0]   div_shift;
  logic             div_ge;
  logic [WID_W-1:0] div_rem_next;
  logic [CNT_W-1:0] div_quo_next;
  logic             div_last;

  // packed store
  logic [WORD_W-1:0] packed_store [MAX_ITEMS];
  logic [WORD_W-1:0] rdata;
  logic [ADDR_W-1:0] rd_addr;
  logic              mem_we;
  logic [ADDR_W-1:0] wr_addr;
  logic [WORD_W-1:0] wr_data;

  state_t state, state_next;

  logic              accept;
  logic              cfg_wr;
  logic [WID_W-1:0]  eff_w;
  logic [CNT_W-1:0]  eff_count;
  logic [WORD_W-1:0] mask;

  // cursor datapath for the exec cycle
  logic [CNT_W-1:0]  cur_sel;
  logic [WID_W-1:0]  lane_sel;
  logic [ADDR_W-1:0] word_sel;
  logic [11:0]       prod;
  logic              cur_ok;
  logic [4:0]        shift;
  logic [WORD_W-1:0] pack_bits;
  logic [CNT_W-1:0]  cur_adv;
  logic [WID_W-1:0]  lane_adv;
  logic [ADDR_W-1:0] word_adv;
  logic              idx_ok;

  // result
  logic              res_valid;
  logic [WORD_W-1:0] res_data;
  logic [1:0]        res_status;

  assign accept = start && (state == ST_IDLE);
  assign busy   = (state != ST_IDLE);
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  assign prdata = (paddr[2] == REG_ITEM_COUNT) ? {{(32-CNT_W){1'b0}}, item_count}
                                                : {{(32-WID_W){1'b0}}, bit_width};

  // width 0 acts as 1, above 32 as 32; count clamps to the store depth
  always_comb begin
    if (bit_width == '0) begin
      eff_w = WID_W'(1);
    end else if (bit_width > WID_W'(WORD_W)) begin
      eff_w = WID_W'(WORD_W);
    end else begin
      eff_w = bit_width;
    end
    if (item_count > CNT_W'(MAX_ITEMS)) begin
      eff_count = CNT_W'(MAX_ITEMS);
    end else begin
      eff_count = item_count;
    end
  end

  // shifting by 32 gives zero, so width 32 yields all ones
  assign mask = ~({WORD_W{1'b1}} << eff_w);

  // one quotient bit per cycle
  assign div_shift    = {div_rem, div_quo[CNT_W-1]};
  assign div_ge       = (div_shift >= {1'b0, div_den});
  assign div_rem_next = div_ge ? WID_W'(div_shift - {1'b0, div_den}) : WID_W'(div_shift);
  assign div_quo_next = {div_quo[CNT_W-2:0], div_ge};
  assign div_last     = (div_cnt == '0);

  // store read address is picked at the accepting edge
  always_comb begin
    case (operation)
      OP_PACK:   rd_addr = pack_word;
      OP_UNPACK: rd_addr = unpack_word;
      default:   rd_addr = word_index;
    endcase
  end

  // cursor check and lane arithmetic
  always_comb begin
    if (op_q == OP_UNPACK) begin
      cur_sel  = unpack_cursor;
      lane_sel = unpack_lane;
      word_sel = unpack_word;
    end else begin
      cur_sel  = pack_cursor;
      lane_sel = pack_lane;
      word_sel = pack_word;
    end
    prod   = 12'(lane_sel) * 12'(eff_w);
    cur_ok = (block_length != '0) && (cur_sel < eff_count) &&
             ({1'b0, word_sel} < block_length) &&
             ((prod + 12'(eff_w)) <= 12'(WORD_W));
    shift  = prod[4:0];
    pack_bits = (val_q & mask) << shift;
    cur_adv = cur_sel + CNT_W'(1);
    if (({1'b0, word_sel} + CNT_W'(1)) >= block_length) begin
      word_adv = '0;
      lane_adv = lane_sel + WID_W'(1);
    end else begin
      word_adv = word_sel + ADDR_W'(1);
      lane_adv = lane_sel;
    end
    idx_ok = ({1'b0, idx_q} < block_length);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    res_valid  = 1'b0;
    res_data   = '0;
    res_status = STAT_OK;
    mem_we     = 1'b0;
    wr_addr    = idx_q;
    wr_data    = val_q;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (operation == OP_RESTART) begin
            state_next = ST_DIV_LANES;
          end else begin
            state_next = ST_EXEC;
          end
        end
      end
      ST_DIV_LANES: begin
        if (div_last) begin
          state_next = ST_DIV_BLEN;
        end
      end
      ST_DIV_BLEN: begin
        if (div_last) begin
          state_next = ST_IDLE;
          res_valid  = 1'b1;
        end
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
        res_valid  = 1'b1;
        case (op_q)
          OP_PACK: begin
            if (cur_ok) begin
              mem_we  = 1'b1;
              wr_addr = pack_word;
              wr_data = (pack_lane == '0) ? pack_bits : (rdata | pack_bits);
            end else begin
              res_status = STAT_CURSOR;
            end
          end
          OP_UNPACK: begin
            if (cur_ok) begin
              res_data = (rdata >> shift) & mask;
            end else begin
              res_status = STAT_CURSOR;
            end
          end
          OP_READ: begin
            if (idx_ok) begin
              res_data = rdata;
            end else begin
              res_status = STAT_RANGE;
            end
          end
          OP_WRITE: begin
            if (idx_ok) begin
              mem_we = 1'b1;
            end else begin
              res_status = STAT_RANGE;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_width  <= WID_W'(1);
      item_count <= CNT_W'(MAX_ITEMS);
    end else if (cfg_wr) begin
      if (paddr[2] == REG_BIT_WIDTH) begin
        bit_width <= pwdata[WID_W-1:0];
      end else begin
        item_count <= pwdata[CNT_W-1:0];
      end
    end
  end

  // cursors and block length
  always_ff @(posedge clk) begin
    if (rst) begin
      pack_cursor   <= '0;
      pack_lane     <= '0;
      pack_word     <= '0;
      unpack_cursor <= '0;
      unpack_lane   <= '0;
      unpack_word   <= '0;
      block_length  <= '0;
    end else if (state == ST_DIV_BLEN && div_last) begin
      block_length  <= div_quo_next;
      pack_cursor   <= '0;
      pack_lane     <= '0;
      pack_word     <= '0;
      unpack_cursor <= '0;
      unpack_lane   <= '0;
      unpack_word   <= '0;
    end else if (state == ST_EXEC && cur_ok) begin
      if (op_q == OP_PACK) begin
        pack_cursor <= cur_adv;
        pack_lane   <= lane_adv;
        pack_word   <= word_adv;
      end else if (op_q == OP_UNPACK) begin
        unpack_cursor <= cur_adv;
        unpack_lane   <= lane_adv;
        unpack_word   <= word_adv;
      end
    end
  end

  // divider: first lanes = 32 / w, then (count + lanes - 1) / lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (accept) begin
      div_quo <= CNT_W'(WORD_W);
      div_den <= eff_w;
      div_rem <= '0;
      div_cnt <= 4'(CNT_W - 1);
    end else if (state == ST_DIV_LANES || state == ST_DIV_BLEN) begin
      if (state == ST_DIV_LANES && div_last) begin
        div_quo <= eff_count + CNT_W'(div_quo_next[WID_W-1:0]) - CNT_W'(1);
        div_den <= div_quo_next[WID_W-1:0];
        div_rem <= '0;
        div_cnt <= 4'(CNT_W - 1);
      end else begin
        div_quo <= div_quo_next;
        div_rem <= div_rem_next;
        div_cnt <= div_cnt - 4'd1;
      end
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= operation;
      val_q <= value;
      idx_q <= word_index;
    end
  end

  // packed store, read data registered
  always_ff @(posedge clk) begin
    if (accept) begin
      rdata <= packed_store[rd_addr];
    end
    if (mem_we) begin
      packed_store[wr_addr] <= wr_data;
    end
  end

  // result registers, one cycle strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res_valid;
    end
    if (res_valid) begin
      data   <= res_data;
      status <= res_status;
    end
  end

endmodule
